// ----- hw/rtl/pftd_pkg.sv -----
// ---------------------------------------------------------------------------
// pftd_pkg: shared types and constants for the prime filter
// Value width, request classes and the queue entry between front and back.
// ---------------------------------------------------------------------------
package pftd_pkg;

	// Width of one matrix element, two's complement
	localparam int VALUE_BITS = 32;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Class given to a request by the front
	localparam logic [1:0] CLS_NOT_PRIME = 2'd0;
	localparam logic [1:0] CLS_PRIME     = 2'd1;
	localparam logic [1:0] CLS_TRIAL     = 2'd2;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last_element;
		logic [1:0]            cls;
	} pftd_entry_t;

	// Push side of the queue
	typedef struct packed {
		logic        valid;
		pftd_entry_t entry;
	} pftd_push_t;

	// Head of the queue as seen by the back
	typedef struct packed {
		logic        avail;
		pftd_entry_t entry;
	} pftd_head_t;

endpackage

// ----- hw/rtl/pftd_if.sv -----
// ---------------------------------------------------------------------------
// pftd_if: element and result channels of the prime filter
// Valid/ready channels; a request moves on an edge with both high.
// ---------------------------------------------------------------------------

// Element channel: value to test and end-of-matrix mark
interface pftd_elem_if;
	import pftd_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic                         last_element;

	modport source (output valid, output value, output last_element, input ready);
	modport sink   (input valid, input value, input last_element, output ready);
endinterface

// Result channel: value passed through, prime flag, end-of-matrix mark
interface pftd_res_if;
	import pftd_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] tested_value;
	logic                         is_prime;
	logic                         last_result;

	modport source (output valid, output tested_value, output is_prime,
		output last_result, input ready);
	modport sink   (input valid, input tested_value, input is_prime,
		input last_result, output ready);
endinterface

// ----- hw/rtl/pftd_front.sv -----
// ---------------------------------------------------------------------------
// pftd_front: accepts elements and sorts out the trivial cases
// Negative, small and even values are settled here; odd values from five
// upward are marked for trial division in the back.
// ---------------------------------------------------------------------------
module pftd_front (
	pftd_elem_if.sink            elem,
	input  logic                 q_full,
	output pftd_pkg::pftd_push_t push
);
	import pftd_pkg::*;

	logic [VALUE_BITS-1:0] v;
	logic [1:0]            cls;

	assign v = elem.value;

	// Classification of the incoming value
	always_comb begin
		if (v[VALUE_BITS-1] || (v < VALUE_BITS'(2))) begin
			cls = CLS_NOT_PRIME;
		end else if (v < VALUE_BITS'(4)) begin
			cls = CLS_PRIME;
		end else if (!v[0]) begin
			cls = CLS_NOT_PRIME;
		end else begin
			cls = CLS_TRIAL;
		end
	end

	// Accept whenever the queue has room
	assign elem.ready              = !q_full;
	assign push.valid              = elem.valid && !q_full;
	assign push.entry.value        = v;
	assign push.entry.last_element = elem.last_element;
	assign push.entry.cls          = cls;

endmodule

// ----- hw/rtl/pftd_fifo.sv -----
// ---------------------------------------------------------------------------
// pftd_fifo: short queue between front and back
// Register-based ring with a fill count; head is shown without a pop.
// ---------------------------------------------------------------------------
module pftd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pftd_pkg::pftd_push_t push,
	output logic                 full,
	input  logic                 pop,
	output pftd_pkg::pftd_head_t head
);
	import pftd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pftd_entry_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && (count_q != '0);
	assign head.avail = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/pftd_back.sv -----
// ---------------------------------------------------------------------------
// pftd_back: trial division engine and result register
// Tries odd divisors k = 3, 5, ... while k*k <= value, with a bit-serial
// restoring remainder unit; k*k is kept by increments of 4k+4.
// ---------------------------------------------------------------------------
module pftd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pftd_pkg::pftd_head_t head,
	output logic                 pop,
	pftd_res_if.source           res
);
	import pftd_pkg::*;

	localparam int SQ_W  = VALUE_BITS + 1;
	localparam int BIT_W = $clog2(VALUE_BITS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BOUND = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]            st_q;
	logic [VALUE_BITS-1:0] v_q;
	logic                  last_q;
	logic                  prime_q;
	logic [VALUE_BITS-1:0] k_q;
	logic [SQ_W-1:0]       sq_q;
	logic [VALUE_BITS-1:0] r_q;
	logic [BIT_W-1:0]      bit_q;

	logic                  res_valid_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic                  res_prime_q;
	logic                  res_last_q;

	logic                  slot_free;
	logic                  take_head;
	logic                  load_res;
	logic [VALUE_BITS-1:0] load_value;
	logic                  load_prime;
	logic                  load_last;
	logic [VALUE_BITS:0]   r_sh;
	logic [VALUE_BITS:0]   r_diff;
	logic [VALUE_BITS-1:0] r_next;
	logic [SQ_W-1:0]       sq_step;

	assign slot_free = !res_valid_q || res.ready;

	// Pop: trial requests start at once, settled ones need a free result slot
	assign take_head = (st_q == ST_IDLE) && head.avail &&
		((head.entry.cls == CLS_TRIAL) || slot_free);
	assign pop = take_head;

	// One remainder step
	assign r_sh   = {r_q, v_q[bit_q]};
	assign r_diff = r_sh - {1'b0, k_q};
	assign r_next = (r_sh >= {1'b0, k_q}) ? r_diff[VALUE_BITS-1:0] : r_sh[VALUE_BITS-1:0];

	// (k+2)^2 - k^2
	assign sq_step = SQ_W'({k_q, 2'b00}) + SQ_W'(4);

	// Result load, either straight from the queue or at the end of a trial
	always_comb begin
		load_res   = 1'b0;
		load_value = v_q;
		load_prime = prime_q;
		load_last  = last_q;
		if (take_head && (head.entry.cls != CLS_TRIAL)) begin
			load_res   = 1'b1;
			load_value = head.entry.value;
			load_prime = (head.entry.cls == CLS_PRIME);
			load_last  = head.entry.last_element;
		end else if ((st_q == ST_EMIT) && slot_free) begin
			load_res = 1'b1;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (take_head && (head.entry.cls == CLS_TRIAL)) begin
						st_q <= ST_BOUND;
					end
				end
				ST_BOUND: begin
					st_q <= (sq_q > {1'b0, v_q}) ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						st_q <= (r_next == '0) ? ST_EMIT : ST_BOUND;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath of the trial division
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				v_q     <= head.entry.value;
				last_q  <= head.entry.last_element;
				k_q     <= VALUE_BITS'(3);
				sq_q    <= SQ_W'(9);
				prime_q <= 1'b1;
			end
			ST_BOUND: begin
				r_q   <= '0;
				bit_q <= BIT_W'(VALUE_BITS - 1);
			end
			ST_DIV: begin
				r_q   <= r_next;
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					if (r_next == '0) begin
						prime_q <= 1'b0;
					end else begin
						k_q  <= k_q + VALUE_BITS'(2);
						sq_q <= sq_q + sq_step;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_value_q <= load_value;
			res_prime_q <= load_prime;
			res_last_q  <= load_last;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.tested_value = res_value_q;
	assign res.is_prime     = res_prime_q;
	assign res.last_result  = res_last_q;

endmodule

// ----- hw/rtl/prime_filter_trial_division.sv -----
// ---------------------------------------------------------------------------
// prime_filter_trial_division: primality test of a stream of elements
// Front classifier, short queue and trial division back end.
// ---------------------------------------------------------------------------
// Use:
//   elem  - valid/ready channel of signed VALUE_BITS-bit matrix elements in
//           row order, with last_element marking the final one.
//   res   - valid/ready channel, one result per element, in order: the value,
//           is_prime and last_result copied from last_element.
// Flow:
//   Negative, 0, 1, 2, 3 and even values are settled by the front; the result
//   goes through the queue into the result register when the back is free.
//   An odd value v from five upward is tried against odd divisors k from three
//   while k*k <= v, stopping at the first that divides v; each divisor takes a
//   bound check and a pass of the bit-serial remainder unit in the back, one
//   quotient bit a cycle. The back takes no new element until the result is loaded.
//   The queue holds two elements so the front keeps accepting while the
//   back works or a result waits.
// Reset: clears the queue, the sequencer and the result valid; no other state.
// Stall: a result waits in the output register while res.ready is low; the
//   back holds once it has another result to load, the queue fills and elem.ready drops.
// ---------------------------------------------------------------------------
module prime_filter_trial_division (
	input  logic       clk,
	input  logic       arst_n,
	pftd_elem_if.sink  elem,
	pftd_res_if.source res
);
	import pftd_pkg::*;

	pftd_push_t push;
	pftd_head_t head;
	logic       q_full;
	logic       pop;

	pftd_front u_front (
		.elem   (elem),
		.q_full (q_full),
		.push   (push)
	);

	pftd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	pftd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule

// ----- hw/rtl/pftd_checker.sv -----
// ---------------------------------------------------------------------------
// pftd_checker: port-level checks of the prime filter
// Result channel holds under stall; a prime flag only on plausible values.
// ---------------------------------------------------------------------------
module pftd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [pftd_pkg::VALUE_BITS-1:0]   res_value,
	input logic                              res_prime,
	input logic                              res_last
);
	import pftd_pkg::*;

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn under stall");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
		$stable(res_value) && $stable(res_prime) && $stable(res_last))
		else $error("result changed under stall");

	// Prime flag never on a negative, zero or one
	a_prime_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_prime |->
		!res_value[VALUE_BITS-1] && (res_value > VALUE_BITS'(1)))
		else $error("prime flag on value below two");

	// The only even prime is two
	a_prime_even: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_prime && !res_value[0] |-> res_value == VALUE_BITS'(2))
		else $error("even value other than two flagged prime");

endmodule

bind prime_filter_trial_division pftd_checker u_pftd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_value (res.tested_value),
	.res_prime (res.is_prime),
	.res_last  (res.last_result)
);
